// File: rtl/core/ame_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor - shared definitions
// Opcodes, field widths and the item record passed along the pipeline.
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int REQ_W  = 4;
    localparam int DATA_W = 32;
    localparam int PC_W   = 10;

    // HLT parks the program counter this far past the end of the program
    localparam logic [PC_W-1:0] HALT_OFFSET = 10'd10;

    typedef enum logic [REQ_W-1:0] {
        OP_DEC = 4'd0,
        OP_LDA = 4'd1,
        OP_LDB = 4'd2,
        OP_LDI = 4'd3,
        OP_STR = 4'd4,
        OP_XCH = 4'd5,
        OP_JMP = 4'd6,
        OP_JZS = 4'd7,
        OP_JVS = 4'd8,
        OP_ADD = 4'd9,
        OP_HLT = 4'd10
    } t_op;

    // One instruction as it travels down the pipeline
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] operand;
        logic              err;
    } t_item;

endpackage

// File: rtl/core/ame_symidx.sv
// ----------------------------------------------------------------------------
// Symbol index unit
// Two pipeline stages that reduce the 32-bit operand modulo the symbol count:
// a byte fold, then a reciprocal multiply and a subtract.
// ----------------------------------------------------------------------------
module ame_symidx import ame_pkg::*; #(
    parameter int NUM_SYMBOLS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [REQ_W-1:0]               i_req_type,
    input  logic [DATA_W-1:0]              i_operand,
    output logic                           o_valid,
    output t_item                          o_item,
    output logic [$clog2(NUM_SYMBOLS)-1:0] o_idx,
    input  logic                           i_dn_ready
);

    localparam int SYM_W = $clog2(NUM_SYMBOLS);
    // Folded value stays below 4 * 255 * 255
    localparam int Y_W   = 18;
    localparam int M_SH  = 27;
    localparam int P_W   = Y_W + M_SH;
    localparam longint unsigned RECIP = (64'd1 << M_SH) / NUM_SYMBOLS + 1;
    localparam int C1 = 256 % NUM_SYMBOLS;
    localparam int C2 = 65536 % NUM_SYMBOLS;
    localparam int C3 = 16777216 % NUM_SYMBOLS;

    logic           r_a_v;
    t_item          r_a_item;
    logic [Y_W-1:0] r_a_y;
    logic           r_b_v;
    t_item          r_b_item;
    logic [Y_W-1:0] r_b_y;
    logic [Y_W-1:0] r_b_q;

    logic           a_ready;
    logic           b_ready;
    logic           take;
    logic [Y_W-1:0] fold_y;
    logic [P_W-1:0] recip_p;
    logic [Y_W-1:0] n_q;
    logic [Y_W-1:0] qn;
    logic [Y_W-1:0] rem;

    // Stage handshake: a stage moves on when the one after it has room
    assign b_ready = !r_b_v || i_dn_ready;
    assign a_ready = !r_a_v || b_ready;
    assign take    = i_valid && a_ready;
    assign o_stall = !a_ready;

    // Fold the operand bytes with their weights modulo the symbol count
    assign fold_y = Y_W'(i_operand[7:0])
                  + Y_W'(i_operand[15:8])  * Y_W'(C1)
                  + Y_W'(i_operand[23:16]) * Y_W'(C2)
                  + Y_W'(i_operand[31:24]) * Y_W'(C3);

    // Quotient of the folded value by reciprocal multiply
    assign recip_p = P_W'(r_a_y) * P_W'(RECIP);
    assign n_q     = recip_p[P_W-1:M_SH];

    // Remainder is the symbol index
    assign qn    = r_b_q * Y_W'(NUM_SYMBOLS);
    assign rem   = r_b_y - qn;
    assign o_idx = rem[SYM_W-1:0];

    assign o_valid = r_b_v;
    assign o_item  = r_b_item;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_v <= i_valid;
            end
            if (b_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_item <= '{req_type: i_req_type, operand: i_operand, err: 1'b0};
            r_a_y    <= fold_y;
        end
        if (r_a_v && b_ready) begin
            r_b_item <= r_a_item;
            r_b_y    <= r_a_y;
            r_b_q    <= n_q;
        end
    end

endmodule

// File: rtl/core/ame_symtab.sv
// ----------------------------------------------------------------------------
// Symbol table stage
// Binds declared symbols to data addresses and looks up the data address of
// each load or store. Entries never declared read as address zero.
// ----------------------------------------------------------------------------
module ame_symtab import ame_pkg::*; #(
    parameter int NUM_SYMBOLS = 16,
    parameter int DATA_DEPTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  t_item                          i_item,
    input  logic [$clog2(NUM_SYMBOLS)-1:0] i_idx,
    output logic                           o_ready,
    output logic                           o_valid,
    output t_item                          o_item,
    output logic [$clog2(DATA_DEPTH)-1:0]  o_addr,
    input  logic                           i_dn_ready
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam int CNT_W  = $clog2(DATA_DEPTH + 1);

    logic                   r_v;
    t_item                  r_item;
    logic [ADDR_W-1:0]      r_addr;
    logic [CNT_W-1:0]       r_free;
    logic [NUM_SYMBOLS-1:0] r_tab_vld;
    logic [ADDR_W-1:0]      r_tab [NUM_SYMBOLS];

    logic take;
    logic is_dec;
    logic full;
    logic dec_ok;

    assign o_ready = !r_v || i_dn_ready;
    assign take    = i_valid && o_ready;
    assign is_dec  = i_item.req_type == OP_DEC;
    assign full    = r_free == CNT_W'(DATA_DEPTH);
    assign dec_ok  = take && is_dec && !full;

    assign o_valid = r_v;
    assign o_item  = r_item;
    assign o_addr  = r_addr;

    // Stage valid, allocation pointer and entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= 1'b0;
            r_free    <= '0;
            r_tab_vld <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (dec_ok) begin
                r_free           <= r_free + CNT_W'(1);
                r_tab_vld[i_idx] <= 1'b1;
            end
        end
    end

    // Table write on declare, registered lookup for everything else
    always_ff @(posedge i_clk) begin
        if (dec_ok) begin
            r_tab[i_idx] <= r_free[ADDR_W-1:0];
        end
        if (take) begin
            r_item <= '{req_type: i_item.req_type,
                        operand:  i_item.operand,
                        err:      is_dec && full};
            r_addr <= r_tab_vld[i_idx] ? r_tab[i_idx] : '0;
        end
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(DATA_DEPTH))
        else $error("allocation pointer past the data store");

    a_full_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && is_dec && full) |=> (r_item.err && $stable(r_free)))
        else $error("declare on full store not flagged or pointer moved");
`endif

endmodule

// File: rtl/core/ame_dmem.sv
// ----------------------------------------------------------------------------
// Data store stage
// Reads the data word for each item and takes stores from the execute stage,
// with a bypass when a store and a read meet at the same address.
// ----------------------------------------------------------------------------
module ame_dmem import ame_pkg::*; #(
    parameter int DATA_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_item                         i_item,
    input  logic [$clog2(DATA_DEPTH)-1:0] i_addr,
    output logic                          o_ready,
    output logic                          o_valid,
    output t_item                         o_item,
    output logic [DATA_W-1:0]             o_data,
    input  logic                          i_dn_ready,
    input  logic [DATA_W-1:0]             i_acc_a
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);

    logic                  r_v;
    t_item                 r_item;
    logic [ADDR_W-1:0]     r_addr;
    logic [DATA_W-1:0]     r_data;
    logic [DATA_DEPTH-1:0] r_dvld;
    logic [DATA_W-1:0]     r_mem [DATA_DEPTH];

    logic take;
    logic wr;

    assign o_ready = !r_v || i_dn_ready;
    assign take    = i_valid && o_ready;
    // A store writes as it leaves for the execute stage
    assign wr      = r_v && i_dn_ready && (r_item.req_type == OP_STR);

    assign o_valid = r_v;
    assign o_item  = r_item;
    assign o_data  = r_data;

    // Stage valid and word valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_dvld <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (wr) begin
                r_dvld[r_addr] <= 1'b1;
            end
        end
    end

    // Store write and registered read with bypass
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_addr] <= i_acc_a;
        end
        if (take) begin
            r_item <= i_item;
            r_addr <= i_addr;
            if (wr && (r_addr == i_addr)) begin
                r_data <= i_acc_a;
            end else if (r_dvld[i_addr]) begin
                r_data <= r_mem[i_addr];
            end else begin
                r_data <= '0;
            end
        end
    end

endmodule

// File: rtl/core/ame_exec.sv
// ----------------------------------------------------------------------------
// Execute stage
// Holds the architectural registers, flags and PC, applies one instruction per
// cycle while not stalled and presents the state after it as the result item.
// ----------------------------------------------------------------------------
module ame_exec import ame_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [PC_W-1:0]   i_cfg_wr_data,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic [DATA_W-1:0] o_acc_a,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PC_W-1:0]   o_pc,
    output logic [DATA_W-1:0] o_reg_a,
    output logic [DATA_W-1:0] o_reg_b,
    output logic              o_zero_flag,
    output logic              o_overflow_flag,
    output logic              o_error
);

    logic [PC_W-1:0]   r_cfg;
    logic [PC_W-1:0]   r_pc;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic              r_zf;
    logic              r_of;
    logic              r_err;
    logic              r_ov;

    logic [PC_W-1:0]   n_pc;
    logic [DATA_W-1:0] n_a;
    logic [DATA_W-1:0] n_b;
    logic              n_zf;
    logic              n_of;

    logic              take;
    logic [PC_W-1:0]   seq_pc;
    logic [PC_W-1:0]   target;
    logic [DATA_W-1:0] sum;

    assign o_ready = !r_ov || !i_stall;
    assign take    = i_valid && o_ready;
    assign seq_pc  = r_pc + PC_W'(1);
    assign target  = i_item.operand[PC_W-1:0];
    assign sum     = r_a + r_b;

    // Next architectural state for the instruction in hand
    always_comb begin
        n_pc = seq_pc;
        n_a  = r_a;
        n_b  = r_b;
        n_zf = r_zf;
        n_of = r_of;
        case (i_item.req_type)
            OP_LDA: begin
                n_a = i_data;
            end
            OP_LDB: begin
                n_b = i_data;
            end
            OP_LDI: begin
                n_a = i_item.operand;
            end
            OP_XCH: begin
                n_a = r_b;
                n_b = r_a;
            end
            OP_JMP: begin
                n_pc = target;
            end
            OP_JZS: begin
                n_pc = r_zf ? target : seq_pc;
            end
            OP_JVS: begin
                n_pc = r_of ? target : seq_pc;
            end
            OP_ADD: begin
                n_a  = sum;
                n_zf = (sum == '0);
                // Signed overflow: like-signed operands, result sign differs
                n_of = ~(r_a[DATA_W-1] ^ r_b[DATA_W-1]) & (r_a[DATA_W-1] ^ sum[DATA_W-1]);
            end
            OP_HLT: begin
                n_pc = r_cfg + HALT_OFFSET;
            end
            default: begin
                // Declare, store and unused codes only advance the counter
                n_pc = seq_pc;
            end
        endcase
    end

    // Architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_pc  <= '0;
            r_a   <= '0;
            r_b   <= '0;
            r_zf  <= 1'b0;
            r_of  <= 1'b0;
            r_err <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (o_ready) begin
                r_ov <= i_valid;
            end
            if (take) begin
                r_pc  <= n_pc;
                r_a   <= n_a;
                r_b   <= n_b;
                r_zf  <= n_zf;
                r_of  <= n_of;
                r_err <= i_item.err;
            end
        end
    end

    assign o_acc_a         = r_a;
    assign o_valid         = r_ov;
    assign o_pc            = r_pc;
    assign o_reg_a         = r_a;
    assign o_reg_b         = r_b;
    assign o_zero_flag     = r_zf;
    assign o_overflow_flag = r_of;
    assign o_error         = r_err;

`ifndef SYNTHESIS
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_item.req_type == OP_HLT)) |=> (r_pc == $past(r_cfg) + HALT_OFFSET))
        else $error("halt did not park the program counter");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(take && (i_item.req_type == OP_ADD)) |=> ($stable(r_zf) && $stable(r_of)))
        else $error("flags changed without an add");
`endif

endmodule

// File: rtl/core/accumulator_machine_executor_core.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor
// Runs one instruction per item on a two-register accumulator machine and
// returns the machine state after each instruction.
// ----------------------------------------------------------------------------
// Takes one instruction per cycle while o_stall is low and returns one result
// item per instruction: the operand is reduced to a symbol index, the symbol
// table is read or updated, the data store is read, and the execute stage
// registers the result. Throughput is set by the execute stage, which updates
// A, B, the flags and the PC once per cycle unless i_stall holds it; its stores
// bypass to a later read of the same word. Symbol table and data store need no
// clearing pass after reset: per-entry valid bits make untouched entries read
// as zero. The user must write program_length through the configuration port
// while no instruction is in flight; the block does not enforce this.
module accumulator_machine_executor_core import ame_pkg::*; #(
    parameter int NUM_SYMBOLS = 16,
    parameter int DATA_DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [PC_W-1:0]          i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_operand,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PC_W-1:0]          o_pc,
    output logic signed [DATA_W-1:0] o_reg_a,
    output logic signed [DATA_W-1:0] o_reg_b,
    output logic                     o_zero_flag,
    output logic                     o_overflow_flag,
    output logic                     o_error
);

    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W = $clog2(DATA_DEPTH);

    logic              idx_valid;
    t_item             idx_item;
    logic [SYM_W-1:0]  idx_sym;
    logic              tab_ready;
    logic              tab_valid;
    t_item             tab_item;
    logic [ADDR_W-1:0] tab_addr;
    logic              mem_ready;
    logic              mem_valid;
    t_item             mem_item;
    logic [DATA_W-1:0] mem_data;
    logic              exe_ready;
    logic [DATA_W-1:0] exe_acc_a;

    // Operand to symbol index
    ame_symidx #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_symidx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_operand  (i_operand),
        .o_valid    (idx_valid),
        .o_item     (idx_item),
        .o_idx      (idx_sym),
        .i_dn_ready (tab_ready)
    );

    // Symbol binding and address lookup
    ame_symtab #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .DATA_DEPTH  (DATA_DEPTH)
    ) u_symtab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (idx_valid),
        .i_item     (idx_item),
        .i_idx      (idx_sym),
        .o_ready    (tab_ready),
        .o_valid    (tab_valid),
        .o_item     (tab_item),
        .o_addr     (tab_addr),
        .i_dn_ready (mem_ready)
    );

    // Data store read and store write
    ame_dmem #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (tab_valid),
        .i_item     (tab_item),
        .i_addr     (tab_addr),
        .o_ready    (mem_ready),
        .o_valid    (mem_valid),
        .o_item     (mem_item),
        .o_data     (mem_data),
        .i_dn_ready (exe_ready),
        .i_acc_a    (exe_acc_a)
    );

    // Execute and result register
    ame_exec u_exec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (mem_valid),
        .i_item          (mem_item),
        .i_data          (mem_data),
        .o_ready         (exe_ready),
        .o_acc_a         (exe_acc_a),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pc            (o_pc),
        .o_reg_a         (o_reg_a),
        .o_reg_b         (o_reg_b),
        .o_zero_flag     (o_zero_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_error         (o_error)
    );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor - testbench
// Drives instruction items into the core with random gaps and stalls, tracks
// the machine state (A, B, flags, PC, symbol table, data store) alongside it
// and compares every returned state item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import ame_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYMS        = 16;
    localparam int DEPTH       = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int LEN_MAX     = 1013;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;

    // Machine state as returned after one instruction
    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [DATA_W-1:0] reg_a;
        logic [DATA_W-1:0] reg_b;
        logic              zero_f;
        logic              ovf_f;
        logic              err;
    } t_mach_state;

    // Track the machine and hold the states it must return, oldest first
    class machine_checker;
        logic [DATA_W-1:0] reg_a;
        logic [DATA_W-1:0] reg_b;
        logic              zero_f;
        logic              ovf_f;
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   prog_len;
        logic [ADDR_W:0]   free_ptr;
        logic [ADDR_W-1:0] sym_addr [SYMS];
        logic [DATA_W-1:0] words [DEPTH];
        t_mach_state       expected_states [$];
        int                mismatch_cnt;

        function void clear();
            reg_a    = '0;
            reg_b    = '0;
            zero_f   = 1'b0;
            ovf_f    = 1'b0;
            pc       = '0;
            prog_len = '0;
            free_ptr = '0;
            foreach (sym_addr[i]) sym_addr[i] = '0;
            foreach (words[i]) words[i] = '0;
            expected_states.delete();
            mismatch_cnt = 0;
        endfunction

        function void set_length(logic [PC_W-1:0] len);
            prog_len = len;
        endfunction

        // Execute one instruction and queue the state it leaves behind
        function void note_instr(logic [REQ_W-1:0] op, logic [DATA_W-1:0] opnd);
            logic [PC_W-1:0]   next_pc;
            logic [PC_W-1:0]   target;
            logic [DATA_W-1:0] sum;
            logic [DATA_W-1:0] tmp;
            logic              err;
            int                sym;
            int                addr;
            t_mach_state       st;
            next_pc = pc + 1'b1;
            target  = opnd[PC_W-1:0];
            sym     = int'(opnd % SYMS);
            addr    = int'(sym_addr[sym]);
            err     = 1'b0;
            case (op)
                OP_DEC: begin
                    if (free_ptr < DEPTH) begin
                        sym_addr[sym] = free_ptr[ADDR_W-1:0];
                        free_ptr      = free_ptr + 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                    pc = next_pc;
                end
                OP_LDA: begin
                    reg_a = words[addr];
                    pc    = next_pc;
                end
                OP_LDB: begin
                    reg_b = words[addr];
                    pc    = next_pc;
                end
                OP_LDI: begin
                    reg_a = opnd;
                    pc    = next_pc;
                end
                OP_STR: begin
                    words[addr] = reg_a;
                    pc          = next_pc;
                end
                OP_XCH: begin
                    tmp   = reg_a;
                    reg_a = reg_b;
                    reg_b = tmp;
                    pc    = next_pc;
                end
                OP_JMP: pc = target;
                OP_JZS: pc = zero_f ? target : next_pc;
                OP_JVS: pc = ovf_f ? target : next_pc;
                OP_ADD: begin
                    sum    = reg_a + reg_b;
                    ovf_f  = (reg_a[DATA_W-1] == reg_b[DATA_W-1]) &&
                             (sum[DATA_W-1] != reg_a[DATA_W-1]);
                    zero_f = (sum == '0);
                    reg_a  = sum;
                    pc     = next_pc;
                end
                OP_HLT: pc = prog_len + HALT_OFFSET;
                default: pc = next_pc;
            endcase
            st.pc     = pc;
            st.reg_a  = reg_a;
            st.reg_b  = reg_b;
            st.zero_f = zero_f;
            st.ovf_f  = ovf_f;
            st.err    = err;
            expected_states.push_back(st);
        endfunction

        function void report(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
            if (mismatch_cnt < 10)
                $display("%s differs: expected %h, got %h", what, exp_v, got_v);
            mismatch_cnt++;
        endfunction

        // Compare a returned state with the oldest one queued
        function void check_state(t_mach_state got);
            t_mach_state exp_s;
            if (expected_states.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("state item with no instruction waiting: pc %h", got.pc);
                mismatch_cnt++;
                return;
            end
            exp_s = expected_states.pop_front();
            if (got.pc !== exp_s.pc)
                report("pc", DATA_W'(exp_s.pc), DATA_W'(got.pc));
            if (got.reg_a !== exp_s.reg_a) report("reg_a", exp_s.reg_a, got.reg_a);
            if (got.reg_b !== exp_s.reg_b) report("reg_b", exp_s.reg_b, got.reg_b);
            if (got.zero_f !== exp_s.zero_f)
                report("zero_flag", DATA_W'(exp_s.zero_f), DATA_W'(got.zero_f));
            if (got.ovf_f !== exp_s.ovf_f)
                report("overflow_flag", DATA_W'(exp_s.ovf_f), DATA_W'(got.ovf_f));
            if (got.err !== exp_s.err)
                report("error", DATA_W'(exp_s.err), DATA_W'(got.err));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_wr_en     = 1'b0;
    logic [PC_W-1:0]          i_cfg_wr_data   = '0;
    logic                     i_valid         = 1'b0;
    logic                     o_stall;
    logic [REQ_W-1:0]         i_req_type      = '0;
    logic signed [DATA_W-1:0] i_operand       = '0;
    logic                     o_valid;
    logic                     i_stall         = 1'b0;
    logic [PC_W-1:0]          o_pc;
    logic signed [DATA_W-1:0] o_reg_a;
    logic signed [DATA_W-1:0] o_reg_b;
    logic                     o_zero_flag;
    logic                     o_overflow_flag;
    logic                     o_error;

    machine_checker sb = new;
    bit             in_fire  = 1'b0;
    bit             idle_on  = 1'b1;
    bit             hold_req = 1'b0;
    int             hold_cnt = 0;
    int             cycle_cnt = 0;

    accumulator_machine_executor_core #(
        .NUM_SYMBOLS (SYMS),
        .DATA_DEPTH  (DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_operand       (i_operand),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pc            (o_pc),
        .o_reg_a         (o_reg_a),
        .o_reg_b         (o_reg_b),
        .o_zero_flag     (o_zero_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_error         (o_error)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sample both handshakes mid-cycle, where every signal has settled
    always @(negedge i_clk) begin
        t_mach_state got;
        in_fire = i_rst_n && i_valid && (o_stall === 1'b0);
        if (in_fire)
            sb.note_instr(i_req_type, i_operand);
        if (i_rst_n && (o_valid === 1'b1) && !i_stall) begin
            got.pc     = o_pc;
            got.reg_a  = o_reg_a;
            got.reg_b  = o_reg_b;
            got.zero_f = o_zero_flag;
            got.ovf_f  = o_overflow_flag;
            got.err    = o_error;
            sb.check_state(got);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt <= HOLD_CYCLES;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < 13);
        end
    end

    // Offer one instruction item and hold it until it is taken
    task automatic send_instr(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] opnd);
        while (idle_on && ($urandom_range(99) < 13)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_operand  <= opnd;
        do
            @(posedge i_clk);
        while (!in_fire);
    endtask

    // Drop valid and wait until every queued state has come back
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_states.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_length(input logic [PC_W-1:0] len);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_length(len);
    endtask

    // Symbol operand: mostly low symbols, upper bits sometimes random
    function automatic logic [DATA_W-1:0] rand_sym();
        logic [DATA_W-1:0] v;
        v = $urandom();
        if ($urandom_range(1))
            v[DATA_W-1:4] = '0;
        v[3:0] = ($urandom_range(3) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
        return v;
    endfunction

    // Immediate: extremes and small values mixed with random words
    function automatic logic [DATA_W-1:0] rand_imm();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom_range(8) - 4;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 8) return OP_DEC;
        else if (r < 19) return OP_LDA;
        else if (r < 30) return OP_LDB;
        else if (r < 44) return OP_LDI;
        else if (r < 56) return OP_STR;
        else if (r < 64) return OP_XCH;
        else if (r < 69) return OP_JMP;
        else if (r < 75) return OP_JZS;
        else if (r < 81) return OP_JVS;
        else if (r < 95) return OP_ADD;
        else if (r < 97) return OP_HLT;
        else return REQ_W'(OP_HLT + 1 + $urandom_range(4));
    endfunction

    // Random part: single instructions with short well-formed sequences mixed in
    task automatic random_burst(input int n);
        int                sent;
        logic [REQ_W-1:0]  op;
        logic [DATA_W-1:0] x;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(9))
                0: begin
                    // sum to zero, then test the zero flag
                    x = rand_imm();
                    send_instr(OP_LDI, x);
                    send_instr(OP_XCH, $urandom());
                    send_instr(OP_LDI, -x);
                    send_instr(OP_ADD, $urandom());
                    send_instr(OP_JZS, $urandom());
                    sent += 5;
                end
                1: begin
                    // large operands, then test the overflow flag
                    send_instr(OP_LDI, rand_imm());
                    send_instr(OP_XCH, $urandom());
                    send_instr(OP_LDI, rand_imm());
                    send_instr(OP_ADD, $urandom());
                    send_instr(OP_JVS, $urandom());
                    sent += 5;
                end
                2: begin
                    // declare, store and read back through one symbol
                    x = rand_sym();
                    send_instr(OP_DEC, x);
                    send_instr(OP_LDI, rand_imm());
                    send_instr(OP_STR, x);
                    send_instr($urandom_range(1) ? OP_LDA : OP_LDB, x);
                    sent += 4;
                end
                default: begin
                    op = pick_op();
                    if (op == OP_LDI)
                        x = rand_imm();
                    else if (op == OP_DEC || op == OP_LDA || op == OP_LDB || op == OP_STR)
                        x = rand_sym();
                    else
                        x = $urandom();
                    send_instr(op, x);
                    sent++;
                end
            endcase
        end
    endtask

    // Directed part: flags, jumps, symbol wrap, undeclared symbol, odd codes
    task automatic run_directed();
        send_instr(OP_LDA, 32'h0000_0005);   // undeclared symbol reads word 0
        send_instr(OP_DEC, 32'h0000_0003);
        send_instr(OP_DEC, 32'hFFFF_FFFF);   // symbol taken from low bits
        send_instr(OP_LDI, 32'h7FFF_FFFF);
        send_instr(OP_STR, 32'h0000_0003);
        send_instr(OP_LDI, 32'h0000_0001);
        send_instr(OP_XCH, 32'h0000_0000);
        send_instr(OP_LDA, 32'h8000_0003);
        send_instr(OP_ADD, 32'h0000_0000);   // positive overflow
        send_instr(OP_JVS, 32'hFFFF_FC05);
        send_instr(OP_JZS, 32'h0000_0012);   // not taken
        send_instr(OP_STR, 32'h0000_000F);
        send_instr(OP_LDI, 32'h8000_0000);
        send_instr(OP_LDB, 32'h0000_000F);
        send_instr(OP_ADD, 32'hFFFF_FFFF);   // negative overflow to zero
        send_instr(OP_JZS, 32'h0000_03FF);
        send_instr(OP_JMP, 32'hFFFF_FFFF);
        send_instr(OP_XCH, 32'hFFFF_FFFF);   // PC wraps to zero
        send_instr(REQ_W'(OP_HLT + 1), 32'h0000_0000);
        send_instr(4'hF, 32'hFFFF_FFFF);
        send_instr(OP_HLT, 32'h0000_0000);
        send_instr(OP_LDI, 32'h0000_0002);
        send_instr(OP_ADD, 32'h0000_0000);   // no overflow, non-zero
        send_instr(OP_JVS, 32'h0000_0100);
    endtask

    initial begin
        sb.clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_length(PC_W'(LEN_MAX));
        run_directed();
        settle();

        // Long receiver hold-off while items keep coming
        write_length('0);
        hold_req = 1'b1;
        random_burst(125);
        settle();

        // Stretch with no idling on either side
        write_length(PC_W'($urandom_range(LEN_MAX)));
        idle_on = 1'b0;
        random_burst(125);
        settle();
        idle_on = 1'b1;

        write_length(PC_W'(LEN_MAX));
        random_burst(125);
        settle();

        write_length(PC_W'($urandom_range(LEN_MAX)));
        random_burst(125);
        settle();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatch_cnt == 0 && sb.expected_states.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
